FILE: hw/rtl/lbpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lbpc_pkg;

	// Number of LEDs driven; only the first three show up in led_levels.
	localparam int NUM_LEDS   = 3;
	localparam int LEVELS_W   = 3;
	localparam int LED_SHOWN  = (NUM_LEDS < LEVELS_W) ? NUM_LEDS : LEVELS_W;

	localparam int LED_IDX_W  = 2;
	localparam int PATTERN_W  = 3;
	localparam int COUNT_W    = 16;
	localparam int TICKS_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int STATUS_W   = 2;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_ON   = 2'd1,
		MODE_FAST = 2'd2,
		MODE_SLOW = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED  = 2'd0,
		ST_PARAM_ERR = 2'd1,
		ST_TICK_DONE = 2'd2
	} status_t;

	typedef enum logic {
		CMD_TICK    = 1'b0,
		CMD_REQUEST = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FAST_ON  = 2'd0,
		CFG_FAST_OFF = 2'd1,
		CFG_SLOW_ON  = 2'd2,
		CFG_SLOW_OFF = 2'd3
	} cfg_idx_t;

	// Largest pattern code that a request may carry.
	localparam logic [PATTERN_W-1:0] PATTERN_MAX = PATTERN_W'(MODE_SLOW);

	typedef struct packed {
		mode_t                     mode;
		logic signed [COUNT_W-1:0] blinks_left;
		logic                      lit;
		logic [TICKS_W-1:0]        phase_left;
	} led_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/led_blink_pattern_controller_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// LED blink pattern controller.
// Input channel (in_valid/in_ready) carries one item per transfer: a tick
// (cmd = 0) that advances the phase of every blinking LED, or a pattern
// request (cmd = 1) that sets one LED to off, on, fast blink or slow blink
// with a blink count (negative = endless).
// Output channel (out_valid/out_ready) returns one result per item: the LED
// levels after the update and a status code.
// An item taken lands in the input register; its result is loaded into the
// output register when stage 1 advances and is offered from then on.
// Throughput: one item per cycle when not stalled; all LEDs update in
// parallel in the single combinational pass between input and output registers.
// When the receiver stalls, the output register holds its result and the
// input register holds the next item; in_ready drops only when both are full.
// Configuration writes (cfg_we/cfg_index/cfg_data) are registered and
// apply when a phase is next loaded.
// Reset (arst_n low) empties both registers, restores the default phase
// lengths (fast 1/1, slow 5/5) and turns every LED off.
module led_blink_pattern_controller_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration
	input  wire logic                             cfg_we,
	input  wire logic [lbpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lbpc_pkg::TICKS_W-1:0]     cfg_data,
	// input channel
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             cmd,
	input  wire logic [lbpc_pkg::LED_IDX_W-1:0]   led_index,
	input  wire logic [lbpc_pkg::PATTERN_W-1:0]   pattern,
	input  wire logic signed [lbpc_pkg::COUNT_W-1:0] num_blinks,
	// output channel
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [lbpc_pkg::LEVELS_W-1:0]         led_levels,
	output logic [lbpc_pkg::STATUS_W-1:0]         status
);
	import lbpc_pkg::*;

	// phase length registers
	logic [TICKS_W-1:0] fast_on_q, fast_off_q, slow_on_q, slow_off_q;

	// input register
	logic                        valid_s1;
	logic                        cmd_s1;
	logic [LED_IDX_W-1:0]        led_index_s1;
	logic [PATTERN_W-1:0]        pattern_s1;
	logic signed [COUNT_W-1:0]   num_blinks_s1;

	// per-LED state
	led_state_t led_q   [NUM_LEDS];
	led_state_t led_nxt [NUM_LEDS];

	logic                 adv_s1;
	logic                 req_ok;
	status_t              status_nxt;
	logic [LEVELS_W-1:0]  levels_nxt;

	// Stage 1 moves on when the output register is empty or being drained.
	assign adv_s1   = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_on_q  <= TICKS_W'(1);
			fast_off_q <= TICKS_W'(1);
			slow_on_q  <= TICKS_W'(5);
			slow_off_q <= TICKS_W'(5);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FAST_ON:  fast_on_q  <= cfg_data;
				CFG_FAST_OFF: fast_off_q <= cfg_data;
				CFG_SLOW_ON:  slow_on_q  <= cfg_data;
				CFG_SLOW_OFF: slow_off_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1         <= cmd;
			led_index_s1   <= led_index;
			pattern_s1     <= pattern;
			num_blinks_s1  <= num_blinks;
		end
	end

	assign req_ok = (int'(led_index_s1) < NUM_LEDS) && (pattern_s1 <= PATTERN_MAX);

	// Next state of every LED for the item in stage 1.
	always_comb begin
		for (int i = 0; i < NUM_LEDS; i++) begin
			led_state_t st;
			logic       toggle;
			logic       fast;
			st     = led_q[i];
			toggle = 1'b0;
			fast   = (st.mode == MODE_FAST);
			if (cmd_t'(cmd_s1) == CMD_TICK) begin
				if (st.mode == MODE_FAST || st.mode == MODE_SLOW) begin
					toggle = 1'b1;
					if (st.phase_left != '0) begin
						st.phase_left = st.phase_left - TICKS_W'(1);
						toggle        = (st.phase_left == '0);
					end
					if (toggle) begin
						if (st.lit) begin
							st.lit        = 1'b0;
							st.phase_left = fast ? fast_off_q : slow_off_q;
						end else begin
							st.lit        = 1'b1;
							st.phase_left = fast ? fast_on_q : slow_on_q;
							if (st.blinks_left > 16'sd0)
								st.blinks_left = st.blinks_left - 16'sd1;
						end
						// count used up: back to dark and off
						if (st.blinks_left == 16'sd0) begin
							st.mode       = MODE_OFF;
							st.lit        = 1'b0;
							st.phase_left = '0;
						end
					end
				end
			end else if (req_ok && (int'(led_index_s1) == i)) begin
				st.mode = mode_t'(pattern_s1[1:0]);
				if (st.mode == MODE_FAST || st.mode == MODE_SLOW) begin
					st.blinks_left = num_blinks_s1;
					st.lit         = 1'b1;
					st.phase_left  = (st.mode == MODE_FAST) ? fast_on_q : slow_on_q;
				end else begin
					st.blinks_left = '0;
					st.lit         = (st.mode == MODE_ON);
					st.phase_left  = '0;
				end
			end
			led_nxt[i] = st;
		end
	end

	always_comb begin
		levels_nxt = '0;
		for (int i = 0; i < LED_SHOWN; i++)
			levels_nxt[i] = led_nxt[i].lit;
	end

	always_comb begin
		if (cmd_t'(cmd_s1) == CMD_TICK)
			status_nxt = ST_TICK_DONE;
		else if (req_ok)
			status_nxt = ST_ACCEPTED;
		else
			status_nxt = ST_PARAM_ERR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				led_q[i].mode        <= MODE_OFF;
				led_q[i].blinks_left <= '0;
				led_q[i].lit         <= 1'b0;
				led_q[i].phase_left  <= '0;
			end
		end else if (adv_s1) begin
			for (int i = 0; i < NUM_LEDS; i++)
				led_q[i] <= led_nxt[i];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			led_levels <= levels_nxt;
			status     <= status_nxt;
		end
	end

endmodule

`default_nettype wire
